// ----- rtl/bpd_pkg.sv -----
// Shared types, register indexes and byte codes for the button-packet drive controller.
package bpd_pkg;

  // Field widths
  localparam int unsigned DistW  = 13;
  localparam int unsigned HoldW  = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 16;

  // Configuration register indexes (byte address bits [3:2])
  localparam logic [1:0] REG_FWD_CLEAR  = 2'd0;
  localparam logic [1:0] REG_AUTO_CLEAR = 2'd1;
  localparam logic [1:0] REG_BACKUP     = 2'd2;

  // Item kinds carried on tuser
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Packet framing bytes and button codes
  localparam logic [7:0] CH_START  = 8'h21;  // '!'
  localparam logic [7:0] CH_BUTTON = 8'h42;  // 'B'
  localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] CH_ONE    = 8'h31;  // '1'
  localparam logic [7:0] CH_FIVE   = 8'h35;  // '5'
  localparam logic [7:0] CH_SIX    = 8'h36;  // '6'
  localparam logic [7:0] CH_SEVEN  = 8'h37;  // '7'
  localparam logic [7:0] CH_EIGHT  = 8'h38;  // '8'

  // Drive modes
  localparam logic [1:0] MODE_STOP = 2'd0;
  localparam logic [1:0] MODE_FWD  = 2'd1;
  localparam logic [1:0] MODE_REV  = 2'd2;
  localparam logic [1:0] MODE_AUTO = 2'd3;

  // Motor commands (two's complement)
  localparam logic [1:0] DRV_STOP = 2'b00;
  localparam logic [1:0] DRV_FWD  = 2'b01;
  localparam logic [1:0] DRV_REV  = 2'b11;

  // Steering positions in half units
  localparam logic [1:0] STEER_RIGHT  = 2'd0;
  localparam logic [1:0] STEER_CENTRE = 2'd1;
  localparam logic [1:0] STEER_LEFT   = 2'd2;

  // Configuration values seen by the datapath
  typedef struct packed {
    logic [DistW-1:0] fwd_clear;
    logic [DistW-1:0] auto_clear;
    logic [HoldW-1:0] backup_ticks;
  } cfg_t;

  // A completed, checked packet from the deframer
  typedef struct packed {
    logic             ok;
    logic [ByteW-1:0] button;
    logic [ByteW-1:0] hit;
  } pkt_t;

  // One result beat
  typedef struct packed {
    logic       backing_up;
    logic       packet_ok;
    logic       led;
    logic [1:0] mode;
    logic [1:0] steer;
    logic [1:0] drive;
  } res_t;

endpackage

// ----- rtl/bpd_cfg.sv -----
// APB-style configuration registers for the drive thresholds and hold length.
module bpd_cfg
  import bpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output cfg_t        cfg
);

  logic [DistW-1:0] fwd_clear_r;
  logic [DistW-1:0] auto_clear_r;
  logic [HoldW-1:0] backup_r;
  logic             wr_en;
  logic [1:0]       idx;

  assign cfg_pready = 1'b1;
  assign idx        = cfg_paddr[3:2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_clear_r  <= DistW'(250);
      auto_clear_r <= DistW'(200);
      backup_r     <= HoldW'(1000);
    end else if (wr_en) begin
      unique case (idx)
        REG_FWD_CLEAR:  fwd_clear_r  <= cfg_pwdata[DistW-1:0];
        REG_AUTO_CLEAR: auto_clear_r <= cfg_pwdata[DistW-1:0];
        REG_BACKUP:     backup_r     <= cfg_pwdata[HoldW-1:0];
        default: ;
      endcase
    end
  end

  // Read-back multiplexer.
  always_comb begin
    unique case (idx)
      REG_FWD_CLEAR:  cfg_prdata = {{(32-DistW){1'b0}}, fwd_clear_r};
      REG_AUTO_CLEAR: cfg_prdata = {{(32-DistW){1'b0}}, auto_clear_r};
      REG_BACKUP:     cfg_prdata = {{(32-HoldW){1'b0}}, backup_r};
      default:        cfg_prdata = 32'd0;
    endcase
  end

  assign cfg.fwd_clear    = fwd_clear_r;
  assign cfg.auto_clear   = auto_clear_r;
  assign cfg.backup_ticks = backup_r;

endmodule

// ----- rtl/bpd_deframe.sv -----
// Five-byte button-packet deframer with checksum test.
module bpd_deframe
  import bpd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [ByteW-1:0] rx_byte,
  output pkt_t             pkt
);

  localparam logic [2:0] PH_HUNT   = 3'd0;
  localparam logic [2:0] PH_TAG    = 3'd1;
  localparam logic [2:0] PH_BUTTON = 3'd2;
  localparam logic [2:0] PH_HIT    = 3'd3;
  localparam logic [2:0] PH_CSUM   = 3'd4;

  logic [2:0]       phase_r, phase_nxt;
  logic [ByteW-1:0] button_r, button_nxt;
  logic [ByteW-1:0] hit_r, hit_nxt;
  logic [ByteW-1:0] sum;
  logic             csum_ok;
  logic             pkt_ok;

  // Checksum is the inverted 8-bit sum of the four leading bytes.
  assign sum     = CH_START + CH_BUTTON + button_r + hit_r;
  assign csum_ok = (rx_byte == ~sum);

  // Parser next state for the byte on hand.
  always_comb begin
    phase_nxt  = phase_r;
    button_nxt = button_r;
    hit_nxt    = hit_r;
    pkt_ok     = 1'b0;
    unique case (phase_r)
      PH_HUNT: begin
        if (rx_byte == CH_START) phase_nxt = PH_TAG;
      end
      PH_TAG: begin
        phase_nxt = (rx_byte == CH_BUTTON) ? PH_BUTTON : PH_HUNT;
      end
      PH_BUTTON: begin
        button_nxt = rx_byte;
        phase_nxt  = PH_HIT;
      end
      PH_HIT: begin
        hit_nxt   = rx_byte;
        phase_nxt = PH_CSUM;
      end
      default: begin
        phase_nxt = PH_HUNT;
        pkt_ok    = csum_ok;
      end
    endcase
  end

  assign pkt.ok     = pkt_ok;
  assign pkt.button = button_r;
  assign pkt.hit    = hit_r;

  // Parser state advances only on accepted bytes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      button_r <= '0;
      hit_r    <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      button_r <= button_nxt;
      hit_r    <= hit_nxt;
    end
  end

endmodule

// ----- rtl/bpd_drive.sv -----
// Drive state: mode, steering, LED, motor command and the autopilot reverse hold.
module bpd_drive
  import bpd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic             op,
  input  logic [DistW-1:0] center_mm,
  input  logic [DistW-1:0] left_mm,
  input  logic [DistW-1:0] right_mm,
  input  pkt_t             pkt,
  input  cfg_t             cfg,
  output res_t             res
);

  logic [1:0]       mode_r, mode_nxt;
  logic [1:0]       steer_r, steer_nxt;
  logic [1:0]       drive_r, drive_nxt;
  logic             led_r, led_nxt;
  logic [HoldW-1:0] hold_r, hold_nxt;
  logic             backing;
  logic             hit;

  assign hit = (pkt.hit == CH_ONE);

  // Next state for one item: packet application on bytes, drive decision on ticks.
  always_comb begin
    mode_nxt  = mode_r;
    steer_nxt = steer_r;
    drive_nxt = drive_r;
    led_nxt   = led_r;
    hold_nxt  = hold_r;
    backing   = 1'b0;
    if (op == OP_BYTE) begin
      backing = (hold_r != '0);
      if (pkt.ok) begin
        led_nxt = (pkt.button != CH_ZERO);
        unique case (pkt.button)
          CH_ONE:   if (hit) mode_nxt = MODE_AUTO;
          CH_FIVE:  mode_nxt = hit ? MODE_FWD : MODE_STOP;
          CH_SIX:   mode_nxt = hit ? MODE_REV : MODE_STOP;
          CH_SEVEN: if (hit && steer_r != STEER_LEFT) steer_nxt = steer_r + 2'd1;
          CH_EIGHT: if (hit && steer_r != STEER_RIGHT) steer_nxt = steer_r - 2'd1;
          default: ;
        endcase
      end
    end else begin
      priority if (hold_r != '0) begin
        hold_nxt  = hold_r - HoldW'(1);
        drive_nxt = DRV_REV;
        backing   = 1'b1;
      end else if (mode_r == MODE_FWD && center_mm >= cfg.fwd_clear) begin
        drive_nxt = DRV_FWD;
      end else if (mode_r == MODE_REV) begin
        drive_nxt = DRV_REV;
      end else if (mode_r == MODE_AUTO) begin
        if (center_mm >= cfg.auto_clear) begin
          drive_nxt = DRV_FWD;
          steer_nxt = STEER_CENTRE;
        end else begin
          // Blocked: reverse while turning away from the nearer side.
          drive_nxt = DRV_REV;
          steer_nxt = (right_mm > left_mm) ? STEER_RIGHT : STEER_LEFT;
          if (cfg.backup_ticks != '0) begin
            hold_nxt = cfg.backup_ticks - HoldW'(1);
            backing  = 1'b1;
          end
        end
      end else begin
        drive_nxt = DRV_STOP;
      end
    end
  end

  // Result fields are the state after this item.
  assign res.drive      = drive_nxt;
  assign res.steer      = steer_nxt;
  assign res.mode       = mode_nxt;
  assign res.led        = led_nxt;
  assign res.packet_ok  = (op == OP_BYTE) & pkt.ok;
  assign res.backing_up = backing;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_STOP;
      steer_r <= STEER_RIGHT;
      drive_r <= DRV_STOP;
      led_r   <= 1'b0;
      hold_r  <= '0;
    end else if (step) begin
      mode_r  <= mode_nxt;
      steer_r <= steer_nxt;
      drive_r <= drive_nxt;
      led_r   <= led_nxt;
      hold_r  <= hold_nxt;
    end
  end

`ifndef SYNTH
  // A pending hold always goes with a reverse command.
  a_hold_rev: assert property (@(posedge clk) disable iff (!rst_n)
    hold_r != '0 |-> drive_r == DRV_REV)
    else $error("hold pending without reverse command");

  // Steering saturates and never reaches the unused code.
  a_steer_range: assert property (@(posedge clk) disable iff (!rst_n)
    steer_r != 2'd3)
    else $error("steering out of range");

  // A reported reverse hold always drives in reverse.
  a_backing_rev: assert property (@(posedge clk) disable iff (!rst_n)
    step && backing |-> drive_nxt == DRV_REV)
    else $error("backing up without reverse command");
`endif

endmodule

// ----- rtl/button_packet_drive_controller_unit.sv -----
// Top level of the button-packet drive controller: input register, datapath, result register.
//
// Each input beat is either a received serial byte (tuser 0) or a control tick with three
// sonar distances (tuser 1), and produces exactly one result beat. A beat is held in an
// input register, evaluated by one pass of combinational logic against the parser and
// drive state, and the result is captured in an output register. One beat per cycle is
// sustained while the result side keeps taking beats. The configuration registers live
// on the APB-style port and must only be written while no beat is in flight.
module button_packet_drive_controller_unit
  import bpd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // Input stream
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,   // rx_byte[7:0], center_mm[20:8], left_mm[33:21],
                                          // right_mm[46:34], zero[47]
  input  logic                in_tuser,   // op: 0 byte, 1 tick
  // Result stream
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,  // drive[1:0], steer[3:2], mode[5:4], led[6],
                                          // packet_ok[7], backing_up[8], zero[15:9]
  // Configuration port
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [3:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  logic                in_valid_r;
  logic                in_op_r;
  logic [InDataW-2:0]  in_data_r;
  logic                out_valid_r;
  logic [OutDataW-1:0] out_data_r;
  logic                advance;
  cfg_t                cfg;
  pkt_t                pkt;
  res_t                res;

  // A held beat moves on when the result register is free or being emptied.
  assign advance   = in_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~in_valid_r | advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_op_r   <= in_tuser;
      in_data_r <= in_tdata[InDataW-2:0];
    end
  end

  bpd_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  bpd_deframe u_deframe (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance & (in_op_r == OP_BYTE)),
    .rx_byte (in_data_r[7:0]),
    .pkt     (pkt)
  );

  bpd_drive u_drive (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .op        (in_op_r),
    .center_mm (in_data_r[20:8]),
    .left_mm   (in_data_r[33:21]),
    .right_mm  (in_data_r[46:34]),
    .pkt       (pkt),
    .cfg       (cfg),
    .res       (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {7'd0, res.backing_up, res.packet_ok, res.led,
                     res.mode, res.steer, res.drive};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- tb/bpd_drive_checker.sv -----
// Watches the beats of the drive controller, predicts each result and compares it.
module bpd_drive_checker
  import bpd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,   // rx_byte, center_mm, left_mm, right_mm, zero
  input  logic                in_tuser,   // op
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [OutDataW-1:0] out_tdata,  // drive, steer, mode, led, packet_ok, backing_up, zero
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [3:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  input  logic                cfg_pready,
  output int unsigned         pending_beats,
  output int unsigned         fail_count
);

  // Progress through the five-byte button packet.
  typedef enum logic [2:0] {
    HUNT_START,
    GOT_START,
    GOT_TAG,
    GOT_BUTTON,
    GOT_HIT
  } frame_phase_e;

  // Shadow copy of the configuration registers.
  logic [DistW-1:0] fwd_clear;
  logic [DistW-1:0] auto_clear;
  logic [HoldW-1:0] backup_len;

  // Shadow copy of the controller state.
  frame_phase_e     frame_phase;
  logic [ByteW-1:0] button_q;
  logic [ByteW-1:0] hit_q;
  logic [1:0]       mode_q;
  logic [1:0]       steer_q;
  logic [1:0]       drive_q;
  logic             led_q;
  logic [HoldW-1:0] hold_left;

  res_t        predicted_results[$];
  int unsigned errors;
  int unsigned beat_index;

  initial begin
    pending_beats = 0;
    fail_count    = 0;
    errors        = 0;
    beat_index    = 0;
  end

  task automatic report_failure(input string msg);
    $display("ERROR: %s", msg);
    errors++;
  endtask

  task automatic compare_field(input string name, input logic [1:0] got,
                               input logic [1:0] want);
    if (got !== want)
      report_failure($sformatf("result beat %0d: %s is %0d, predicted %0d",
                               beat_index, name, got, want));
  endtask

  // Advance the shadow controller by one input beat and form its result.
  task automatic advance_controller(input logic op, input logic [InDataW-1:0] data,
                                    output res_t beat);
    logic [ByteW-1:0] rx;
    logic [ByteW-1:0] sum;
    logic [DistW-1:0] centre;
    logic [DistW-1:0] left;
    logic [DistW-1:0] right;
    logic             hit;
    logic             ok;
    logic             backing;
    rx      = data[7:0];
    centre  = data[20:8];
    left    = data[33:21];
    right   = data[46:34];
    ok      = 1'b0;
    backing = 1'b0;
    if (op == OP_BYTE) begin
      case (frame_phase)
        HUNT_START: if (rx == CH_START) frame_phase = GOT_START;
        // Anything but the tag drops the frame; that byte is not a new start.
        GOT_START:  frame_phase = (rx == CH_BUTTON) ? GOT_TAG : HUNT_START;
        GOT_TAG: begin
          button_q    = rx;
          frame_phase = GOT_BUTTON;
        end
        GOT_BUTTON: begin
          hit_q       = rx;
          frame_phase = GOT_HIT;
        end
        default: begin
          frame_phase = HUNT_START;
          sum = CH_START + CH_BUTTON + button_q + hit_q;
          if (rx == ~sum) begin
            ok    = 1'b1;
            hit   = (hit_q == CH_ONE);
            led_q = (button_q != CH_ZERO);
            case (button_q)
              CH_ONE:   if (hit) mode_q = MODE_AUTO;
              CH_FIVE:  mode_q = hit ? MODE_FWD : MODE_STOP;
              CH_SIX:   mode_q = hit ? MODE_REV : MODE_STOP;
              CH_SEVEN: if (hit && steer_q < STEER_LEFT) steer_q = steer_q + 2'd1;
              CH_EIGHT: if (hit && steer_q > STEER_RIGHT) steer_q = steer_q - 2'd1;
              default: ;
            endcase
          end
        end
      endcase
      backing = (hold_left != '0);
    end else begin
      if (hold_left != '0) begin
        // A held reverse turn overrides whatever the mode says.
        hold_left = hold_left - 1'b1;
        drive_q   = DRV_REV;
        backing   = 1'b1;
      end else if (mode_q == MODE_FWD && centre >= fwd_clear) begin
        drive_q = DRV_FWD;
      end else if (mode_q == MODE_REV) begin
        drive_q = DRV_REV;
      end else if (mode_q == MODE_AUTO) begin
        if (centre >= auto_clear) begin
          drive_q = DRV_FWD;
          steer_q = STEER_CENTRE;
        end else begin
          // Blocked: turn away from the nearer side and, with a nonzero hold length, start the hold.
          drive_q = DRV_REV;
          steer_q = (right > left) ? STEER_RIGHT : STEER_LEFT;
          if (backup_len != '0) begin
            hold_left = backup_len - 1'b1;
            backing   = 1'b1;
          end
        end
      end else begin
        drive_q = DRV_STOP;
      end
    end
    beat.drive      = drive_q;
    beat.steer      = steer_q;
    beat.mode       = mode_q;
    beat.led        = led_q;
    beat.packet_ok  = ok;
    beat.backing_up = backing;
  endtask

  // Results are checked before the input beat of the same edge is predicted.
  always @(posedge clk) begin : monitor
    res_t seen;
    res_t want;
    if (!rst_n) begin
      fwd_clear   = 13'd250;
      auto_clear  = 13'd200;
      backup_len  = 16'd1000;
      frame_phase = HUNT_START;
      button_q    = '0;
      hit_q       = '0;
      mode_q      = MODE_STOP;
      steer_q     = STEER_RIGHT;
      drive_q     = DRV_STOP;
      led_q       = 1'b0;
      hold_left   = '0;
      predicted_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        seen = res_t'(out_tdata[8:0]);
        beat_index++;
        if (predicted_results.size() == 0) begin
          report_failure($sformatf("result beat %0d arrived with nothing predicted",
                                   beat_index));
        end else begin
          want = predicted_results.pop_front();
          compare_field("drive", seen.drive, want.drive);
          compare_field("steer", seen.steer, want.steer);
          compare_field("mode", seen.mode, want.mode);
          compare_field("led", seen.led, want.led);
          compare_field("packet_ok", seen.packet_ok, want.packet_ok);
          compare_field("backing_up", seen.backing_up, want.backing_up);
        end
      end
      // Register writes.
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          REG_FWD_CLEAR:  fwd_clear  = cfg_pwdata[DistW-1:0];
          REG_AUTO_CLEAR: auto_clear = cfg_pwdata[DistW-1:0];
          REG_BACKUP:     backup_len = cfg_pwdata[HoldW-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        advance_controller(in_tuser, in_tdata, want);
        predicted_results.push_back(want);
      end
    end
    pending_beats <= predicted_results.size();
    fail_count    <= errors;
  end

endmodule

// ----- tb/tb.sv -----
// Stimulus and verdict for the button-packet drive controller.
module tb;
  import bpd_pkg::*;

  localparam int CycleLimit = 300000;
  localparam int PhaseItems = 100;

  // Receiver stall styles, picked anew each time the low six bits of stall_cycle are zero.
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_PERIODIC,
    RX_SPARSE
  } ready_style_e;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_tvalid   = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata    = '0;
  logic                in_tuser    = OP_BYTE;
  logic                out_tvalid;
  logic                out_tready  = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_psel    = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite  = 1'b0;
  logic [3:0]          cfg_paddr   = '0;
  logic [31:0]         cfg_pwdata  = '0;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  int unsigned  pending_beats;
  int unsigned  fail_count;
  int           burst_left  = 0;
  int           items_sent  = 0;
  int           cycle_count = 0;
  logic [7:0]   stall_cycle = '0;
  ready_style_e stall_style = RX_ALWAYS;
  int           fwd_thr     = 250;
  int           auto_thr    = 200;

  button_packet_drive_controller_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  bpd_drive_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_pready    (cfg_pready),
    .pending_beats (pending_beats),
    .fail_count    (fail_count)
  );

  // Clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side back-pressure.
  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 8'd1;
    if (stall_cycle[5:0] == 6'd0) stall_style <= ready_style_e'($urandom_range(0, 3));
    case (stall_style)
      RX_ALWAYS:   out_tready <= 1'b1;
      RX_COIN:     out_tready <= 1'($urandom_range(0, 1));
      RX_PERIODIC: out_tready <= (stall_cycle[2:0] != 3'd5);
      default:     out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Watchdog.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // One APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [1:0] index, input int value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {index, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Hold off the sender until every predicted result has come back.
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_beats != 0);
    repeat (4) @(posedge clk);
  endtask

  // Offer one beat, opening a new burst after a random gap when the last one ran out.
  task automatic send_item(input logic op, input logic [7:0] rx, input int centre,
                           input int left, input int right);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tuser  <= op;
    in_tdata  <= {1'b0, right[12:0], left[12:0], centre[12:0], rx};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // A full button packet, with a corrupted checksum when good is clear.
  task automatic send_packet(input logic [7:0] button, input logic [7:0] hit,
                             input logic good);
    logic [7:0] check;
    check = ~(CH_START + CH_BUTTON + button + hit);
    if (!good) check = check ^ 8'($urandom_range(1, 255));
    send_item(OP_BYTE, CH_START, 0, 0, 0);
    send_item(OP_BYTE, CH_BUTTON, 0, 0, 0);
    send_item(OP_BYTE, button, 0, 0, 0);
    send_item(OP_BYTE, hit, 0, 0, 0);
    send_item(OP_BYTE, check, 0, 0, 0);
  endtask

  // Distance: full range, close to a threshold, an extreme or a short range.
  function automatic int pick_distance(input int thr);
    int d;
    case ($urandom_range(0, 3))
      0: d = $urandom_range(0, 8191);
      1: d = thr + $urandom_range(0, 4) - 2;
      2: d = $urandom_range(0, 1) ? 8191 : 0;
      default: d = $urandom_range(0, 400);
    endcase
    if (d < 0) d = 0;
    if (d > 8191) d = 8191;
    return d;
  endfunction

  initial begin : stimulus
    int         phase;
    int         phase_start;
    int         backup_len;
    int         pick;
    int         centre;
    int         left;
    int         right;
    logic       paused;
    logic [7:0] button;
    logic [7:0] hit;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part with a short hold.
    write_reg(REG_FWD_CLEAR, 250);
    write_reg(REG_AUTO_CLEAR, 200);
    write_reg(REG_BACKUP, 3);
    send_item(OP_TICK, 8'h00, 0, 0, 0);
    send_item(OP_TICK, 8'hFF, 8191, 8191, 8191);
    send_item(OP_BYTE, 8'hFF, 0, 0, 0);
    // Start byte followed by a wrong tag, then a lone tag.
    send_item(OP_BYTE, CH_START, 0, 0, 0);
    send_item(OP_BYTE, 8'h58, 0, 0, 0);
    send_item(OP_BYTE, CH_BUTTON, 0, 0, 0);
    send_packet(CH_FIVE, CH_ONE, 1'b1);
    // Forward mode just under and at the clearance.
    send_item(OP_TICK, 8'h00, 249, 0, 0);
    send_item(OP_TICK, 8'h00, 250, 0, 0);
    send_packet(CH_ONE, CH_ONE, 1'b0);
    send_packet(CH_ONE, CH_ONE, 1'b1);
    // Autopilot blocked: reverse turn starts, then is held.
    send_item(OP_TICK, 8'h00, 0, 5, 9);
    send_item(OP_TICK, 8'h00, 0, 9, 5);

    // Random phases, each under its own register setting.
    for (phase = 0; phase < 5; phase++) begin
      wait_for_results();
      case (phase)
        0: begin fwd_thr = 300;  auto_thr = 200;  backup_len = 5;     end
        1: begin fwd_thr = 0;    auto_thr = 8191; backup_len = 0;     end
        2: begin fwd_thr = 8191; auto_thr = 0;    backup_len = 1;     end
        3: begin
          fwd_thr    = $urandom_range(0, 8191);
          auto_thr   = $urandom_range(0, 8191);
          backup_len = $urandom_range(0, 12);
        end
        default: begin
          fwd_thr    = $urandom_range(0, 8191);
          auto_thr   = $urandom_range(0, 8191);
          backup_len = 65535;
        end
      endcase
      write_reg(REG_FWD_CLEAR, fwd_thr);
      write_reg(REG_AUTO_CLEAR, auto_thr);
      write_reg(REG_BACKUP, backup_len);
      phase_start = items_sent;
      paused      = 1'b0;
      while (items_sent - phase_start < PhaseItems) begin
        if (!paused && items_sent - phase_start >= PhaseItems / 2) begin
          wait_for_results();
          paused = 1'b1;
        end
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          // Mostly well-formed packets with a meaningful button.
          case ($urandom_range(0, 7))
            0: button = CH_ZERO;
            1: button = CH_ONE;
            2: button = CH_FIVE;
            3: button = CH_SIX;
            4: button = CH_SEVEN;
            5: button = CH_EIGHT;
            6: button = 8'($urandom_range(0, 255));
            default: button = $urandom_range(0, 1) ? CH_SEVEN : CH_EIGHT;
          endcase
          hit = ($urandom_range(0, 3) != 0) ? CH_ONE : 8'($urandom_range(0, 255));
          send_packet(button, hit, $urandom_range(0, 6) != 0);
        end else if (pick < 85) begin
          centre = pick_distance($urandom_range(0, 1) ? fwd_thr : auto_thr);
          left   = pick_distance(centre);
          right  = ($urandom_range(0, 3) == 0) ? left : pick_distance(left);
          send_item(OP_TICK, 8'($urandom_range(0, 255)), centre, left, right);
        end else begin
          // Noise bytes that may start or break a frame.
          case ($urandom_range(0, 3))
            0: send_item(OP_BYTE, CH_START, 0, 0, 0);
            1: send_item(OP_BYTE, CH_BUTTON, 0, 0, 0);
            default: send_item(OP_BYTE, 8'($urandom_range(0, 255)), 0, 0, 0);
          endcase
        end
      end
    end

    wait_for_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
